[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ellipse rasterizer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DEFR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// next-cycle implication
`define DEFR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

[src/defr_pkg.sv]
// ----------------------------------------------------------------------------
// defr_pkg
// Types, widths and codes shared by the drag ellipse fill rasterizer.
// ----------------------------------------------------------------------------
package defr_pkg;

   localparam int unsigned CANVAS_SIZE_DEF = 2048;

   localparam int unsigned COORD_W = 11;  // canvas coordinate
   localparam int unsigned HALF_W  = 10;  // half span a, b, focal offset c
   localparam int unsigned SQ_W    = 20;  // a*a, b*b
   localparam int unsigned RSQ_W   = 22;  // R*R, squared focal distance term
   localparam int unsigned DIFF_W  = 13;  // signed offset minus focus
   localparam int unsigned RSUM_W  = 23;  // r1, r2
   localparam int unsigned DSIG_W  = 25;  // signed D = R*R - r1 - r2
   localparam int unsigned PROD_W  = 44;  // r1*r2, D*D
   localparam int unsigned ROOT_W  = 21;  // root unit working width
   localparam int unsigned COLOR_W = 32;

   localparam logic [COLOR_W-1:0] COLOR_RESET = 32'hC819FFFF;
   localparam logic [ROOT_W-1:0]  ROOT_TOP    = 21'h100000;

   typedef enum logic {
      OPER_MOUSE = 1'b0,
      OPER_TICK  = 1'b1
   } oper_type;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_UPDATE = 2'd2,
      KIND_COMMIT = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SQUARE,
      ST_ROOT_LOAD,
      ST_ROOT_RUN,
      ST_PIX_SQ,
      ST_PIX_SUM,
      ST_PIX_MUL,
      ST_PIX_STEP,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_RELEASE,
      DP_SET_ANCHOR,
      DP_STOP,
      DP_BOX,
      DP_SQUARE,
      DP_ROOT_START,
      DP_ROOT_SAVE,
      DP_PIX_DIFF,
      DP_PIX_SQ,
      DP_PIX_SUM,
      DP_PIX_MUL,
      DP_PIX_STEP,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      set_kind;
      kind_type  kind;
   } cmd_type;

   typedef struct packed {
      oper_type oper;
      logic     pressed;
      logic     anchor_valid;
      logic     scanning;
      logic     scan_done;
      logic     root_busy;
      logic     hit;
      logic     out_free;
   } status_type;

endpackage

[src/defr_isqrt.sv]
// ----------------------------------------------------------------------------
// defr_isqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module defr_isqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [defr_pkg::SQ_W-1:0]         value,
   output logic                              busy,
   output logic [defr_pkg::HALF_W-1:0]       root
);

   logic [defr_pkg::ROOT_W-1:0] rem_ff, rem_in;
   logic [defr_pkg::ROOT_W-1:0] res_ff, res_in;
   logic [defr_pkg::ROOT_W-1:0] bit_ff, bit_in;
   logic                        busy_ff, busy_in;
   logic [defr_pkg::ROOT_W-1:0] trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = defr_pkg::ROOT_W'(value);
         res_in  = '0;
         bit_in  = defr_pkg::ROOT_TOP;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         // last digit done
         if (bit_ff[0]) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign busy = busy_ff;
   assign root = res_ff[defr_pkg::HALF_W-1:0];

endmodule

[src/defr_datapath.sv]
// ----------------------------------------------------------------------------
// defr_datapath
// Box setup, scan counters, pixel inside test and result register.
// ----------------------------------------------------------------------------
module defr_datapath #(
   parameter int unsigned CANVAS_SIZE = defr_pkg::CANVAS_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  defr_pkg::cmd_type                 cmd,
   output defr_pkg::status_type              status,
   input  logic                              req_operation,
   input  logic                              req_pressed,
   input  logic [defr_pkg::COORD_W-1:0]      req_pos_x,
   input  logic [defr_pkg::COORD_W-1:0]      req_pos_y,
   input  logic                              csr_wr_en,
   input  logic [defr_pkg::COLOR_W-1:0]      csr_wr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_kind,
   output logic [defr_pkg::COORD_W-1:0]      rsp_pixel_x,
   output logic [defr_pkg::COORD_W-1:0]      rsp_pixel_y,
   output logic [defr_pkg::COLOR_W-1:0]      rsp_pixel_color
);

   localparam int unsigned CW = defr_pkg::COORD_W;
   localparam int unsigned HW = defr_pkg::HALF_W;
   localparam int unsigned DW = defr_pkg::DIFF_W;
   localparam logic [31:0] CoordLimit = 32'(CANVAS_SIZE - 1);

   function automatic logic [defr_pkg::RSQ_W-1:0] sq_diff(input logic signed [DW-1:0] d);
      logic signed [2*DW-1:0] p;
      p = d * d;
      return p[defr_pkg::RSQ_W-1:0];
   endfunction

   // input capture
   defr_pkg::oper_type oper_ff, oper_in;
   logic               pressed_ff, pressed_in;
   logic [CW-1:0]      cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   // drag and box state
   logic               anchor_valid_ff, anchor_valid_in;
   logic [CW-1:0]      anchor_x_ff, anchor_x_in, anchor_y_ff, anchor_y_in;
   logic [CW-1:0]      center_x_ff, center_x_in, center_y_ff, center_y_in;
   logic [HW-1:0]      half_w_ff, half_w_in, half_h_ff, half_h_in;
   logic [HW-1:0]      focal_ff, focal_in;
   logic               foci_on_x_ff, foci_on_x_in;
   logic [CW-1:0]      scan_dx_ff, scan_dx_in, scan_dy_ff, scan_dy_in;
   logic               scanning_ff, scanning_in;
   logic [defr_pkg::SQ_W-1:0]  a_sq_ff, a_sq_in, b_sq_ff, b_sq_in;
   logic [defr_pkg::RSQ_W-1:0] r_sq_ff, r_sq_in;
   // pixel test pipeline registers
   logic signed [DW-1:0] d1x_ff, d1x_in, d1y_ff, d1y_in;
   logic signed [DW-1:0] d2x_ff, d2x_in, d2y_ff, d2y_in;
   logic [CW-1:0]        pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic [defr_pkg::RSQ_W-1:0]  s1x_ff, s1x_in, s1y_ff, s1y_in;
   logic [defr_pkg::RSQ_W-1:0]  s2x_ff, s2x_in, s2y_ff, s2y_in;
   logic [defr_pkg::RSUM_W-1:0] r1_ff, r1_in, r2_ff, r2_in;
   logic signed [defr_pkg::DSIG_W-1:0] dval_ff, dval_in;
   logic                        d_pos_ff, d_pos_in;
   logic [defr_pkg::PROD_W-1:0] rr_ff, rr_in, dd_ff, dd_in;
   // result
   defr_pkg::kind_type          kind_ff, kind_in;
   logic [defr_pkg::COLOR_W-1:0] color_ff, color_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  rsp_kind_ff, rsp_kind_in;
   logic [CW-1:0]               rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [defr_pkg::COLOR_W-1:0] rsp_color_ff, rsp_color_in;

   // combinational helpers
   logic [CW-1:0]        clamp_x, clamp_y, span_x, span_y;
   logic [CW:0]          sum_x, sum_y, dy_next;
   logic [HW-1:0]        big_half;
   logic [CW-1:0]        big_r;
   logic [defr_pkg::SQ_W-1:0] sq_gap;
   logic signed [DW-1:0] u_val, v_val, fx, fy;
   logic [defr_pkg::RSUM_W-1:0] r1_c, r2_c;
   logic signed [defr_pkg::DSIG_W-1:0] d_c;
   logic                 root_busy;
   logic [HW-1:0]        root_val;
   logic                 out_free;

   assign clamp_x = (32'(req_pos_x) > CoordLimit) ? CoordLimit[CW-1:0] : req_pos_x;
   assign clamp_y = (32'(req_pos_y) > CoordLimit) ? CoordLimit[CW-1:0] : req_pos_y;

   assign span_x = (anchor_x_ff > cur_x_ff) ? anchor_x_ff - cur_x_ff : cur_x_ff - anchor_x_ff;
   assign span_y = (anchor_y_ff > cur_y_ff) ? anchor_y_ff - cur_y_ff : cur_y_ff - anchor_y_ff;
   assign sum_x  = {1'b0, anchor_x_ff} + {1'b0, cur_x_ff};
   assign sum_y  = {1'b0, anchor_y_ff} + {1'b0, cur_y_ff};

   assign big_half = (half_w_ff > half_h_ff) ? half_w_ff : half_h_ff;
   assign big_r    = {big_half, 1'b0};
   assign sq_gap   = (a_sq_ff > b_sq_ff) ? a_sq_ff - b_sq_ff : b_sq_ff - a_sq_ff;

   assign u_val = $signed({2'b00, scan_dx_ff}) - $signed({3'b000, half_w_ff});
   assign v_val = $signed({2'b00, scan_dy_ff}) - $signed({3'b000, half_h_ff});
   assign fx    = foci_on_x_ff ? $signed({3'b000, focal_ff}) : '0;
   assign fy    = foci_on_x_ff ? '0 : $signed({3'b000, focal_ff});

   assign r1_c = defr_pkg::RSUM_W'(s1x_ff) + defr_pkg::RSUM_W'(s1y_ff);
   assign r2_c = defr_pkg::RSUM_W'(s2x_ff) + defr_pkg::RSUM_W'(s2y_ff);
   assign d_c  = $signed({3'b000, r_sq_ff}) - $signed({2'b00, r1_c})
               - $signed({2'b00, r2_c});

   assign dy_next  = {1'b0, scan_dy_ff} + (CW+1)'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   defr_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == defr_pkg::DP_ROOT_START),
      .value (sq_gap),
      .busy  (root_busy),
      .root  (root_val)
   );

   always_comb begin
      oper_in         = oper_ff;
      pressed_in      = pressed_ff;
      cur_x_in        = cur_x_ff;
      cur_y_in        = cur_y_ff;
      anchor_valid_in = anchor_valid_ff;
      anchor_x_in     = anchor_x_ff;
      anchor_y_in     = anchor_y_ff;
      center_x_in     = center_x_ff;
      center_y_in     = center_y_ff;
      half_w_in       = half_w_ff;
      half_h_in       = half_h_ff;
      focal_in        = focal_ff;
      foci_on_x_in    = foci_on_x_ff;
      scan_dx_in      = scan_dx_ff;
      scan_dy_in      = scan_dy_ff;
      scanning_in     = scanning_ff;
      a_sq_in         = a_sq_ff;
      b_sq_in         = b_sq_ff;
      r_sq_in         = r_sq_ff;
      d1x_in          = d1x_ff;
      d1y_in          = d1y_ff;
      d2x_in          = d2x_ff;
      d2y_in          = d2y_ff;
      pend_x_in       = pend_x_ff;
      pend_y_in       = pend_y_ff;
      s1x_in          = s1x_ff;
      s1y_in          = s1y_ff;
      s2x_in          = s2x_ff;
      s2y_in          = s2y_ff;
      r1_in           = r1_ff;
      r2_in           = r2_ff;
      dval_in         = dval_ff;
      d_pos_in        = d_pos_ff;
      rr_in           = rr_ff;
      dd_in           = dd_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_kind_in     = rsp_kind_ff;
      rsp_x_in        = rsp_x_ff;
      rsp_y_in        = rsp_y_ff;
      rsp_color_in    = rsp_color_ff;
      kind_in         = cmd.set_kind ? cmd.kind : kind_ff;
      color_in        = csr_wr_en ? csr_wr_data : color_ff;

      unique case (cmd.op)
         defr_pkg::DP_NOP, defr_pkg::DP_ROOT_START: begin
         end
         defr_pkg::DP_CAPTURE: begin
            oper_in    = defr_pkg::oper_type'(req_operation);
            pressed_in = req_pressed;
            cur_x_in   = clamp_x;
            cur_y_in   = clamp_y;
         end
         defr_pkg::DP_RELEASE: begin
            anchor_valid_in = 1'b0;
            scanning_in     = 1'b0;
         end
         defr_pkg::DP_SET_ANCHOR: begin
            anchor_valid_in = 1'b1;
            anchor_x_in     = cur_x_ff;
            anchor_y_in     = cur_y_ff;
            scanning_in     = 1'b0;
         end
         defr_pkg::DP_STOP: begin
            scanning_in = 1'b0;
         end
         defr_pkg::DP_BOX: begin
            half_w_in   = span_x[CW-1:1];
            half_h_in   = span_y[CW-1:1];
            center_x_in = sum_x[CW:1];
            center_y_in = sum_y[CW:1];
            scanning_in = 1'b0;
         end
         defr_pkg::DP_SQUARE: begin
            a_sq_in = defr_pkg::SQ_W'(half_w_ff) * defr_pkg::SQ_W'(half_w_ff);
            b_sq_in = defr_pkg::SQ_W'(half_h_ff) * defr_pkg::SQ_W'(half_h_ff);
            r_sq_in = defr_pkg::RSQ_W'(big_r) * defr_pkg::RSQ_W'(big_r);
         end
         defr_pkg::DP_ROOT_SAVE: begin
            focal_in     = root_val;
            foci_on_x_in = half_w_ff > half_h_ff;
            scan_dx_in   = '0;
            scan_dy_in   = '0;
            scanning_in  = 1'b1;
         end
         defr_pkg::DP_PIX_DIFF: begin
            d1x_in    = u_val - fx;
            d1y_in    = v_val - fy;
            d2x_in    = u_val + fx;
            d2y_in    = v_val + fy;
            pend_x_in = center_x_ff + scan_dx_ff - {1'b0, half_w_ff};
            pend_y_in = center_y_ff + scan_dy_ff - {1'b0, half_h_ff};
         end
         defr_pkg::DP_PIX_SQ: begin
            s1x_in = sq_diff(d1x_ff);
            s1y_in = sq_diff(d1y_ff);
            s2x_in = sq_diff(d2x_ff);
            s2y_in = sq_diff(d2y_ff);
         end
         defr_pkg::DP_PIX_SUM: begin
            r1_in    = r1_c;
            r2_in    = r2_c;
            dval_in  = d_c;
            d_pos_in = !d_c[defr_pkg::DSIG_W-1] && (d_c != '0);
         end
         defr_pkg::DP_PIX_MUL: begin
            // operands fit 22 bits whenever D is positive
            rr_in = defr_pkg::PROD_W'(r1_ff[defr_pkg::RSQ_W-1:0])
                  * defr_pkg::PROD_W'(r2_ff[defr_pkg::RSQ_W-1:0]);
            dd_in = defr_pkg::PROD_W'(dval_ff[defr_pkg::RSQ_W-1:0])
                  * defr_pkg::PROD_W'(dval_ff[defr_pkg::RSQ_W-1:0]);
         end
         defr_pkg::DP_PIX_STEP: begin
            if (dy_next >= {1'b0, half_h_ff, 1'b0}) begin
               scan_dy_in = '0;
               scan_dx_in = scan_dx_ff + CW'(1);
            end else begin
               scan_dy_in = dy_next[CW-1:0];
            end
         end
         defr_pkg::DP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = kind_ff;
            if (kind_ff == defr_pkg::KIND_PIXEL) begin
               rsp_x_in     = pend_x_ff;
               rsp_y_in     = pend_y_ff;
               rsp_color_in = color_ff;
            end else begin
               rsp_x_in     = '0;
               rsp_y_in     = '0;
               rsp_color_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_valid_ff <= 1'b0;
         scanning_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         color_ff        <= defr_pkg::COLOR_RESET;
      end else begin
         anchor_valid_ff <= anchor_valid_in;
         scanning_ff     <= scanning_in;
         rsp_valid_ff    <= rsp_valid_in;
         color_ff        <= color_in;
      end
      oper_ff      <= oper_in;
      pressed_ff   <= pressed_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      anchor_x_ff  <= anchor_x_in;
      anchor_y_ff  <= anchor_y_in;
      center_x_ff  <= center_x_in;
      center_y_ff  <= center_y_in;
      half_w_ff    <= half_w_in;
      half_h_ff    <= half_h_in;
      focal_ff     <= focal_in;
      foci_on_x_ff <= foci_on_x_in;
      scan_dx_ff   <= scan_dx_in;
      scan_dy_ff   <= scan_dy_in;
      a_sq_ff      <= a_sq_in;
      b_sq_ff      <= b_sq_in;
      r_sq_ff      <= r_sq_in;
      d1x_ff       <= d1x_in;
      d1y_ff       <= d1y_in;
      d2x_ff       <= d2x_in;
      d2y_ff       <= d2y_in;
      pend_x_ff    <= pend_x_in;
      pend_y_ff    <= pend_y_in;
      s1x_ff       <= s1x_in;
      s1y_ff       <= s1y_in;
      s2x_ff       <= s2x_in;
      s2y_ff       <= s2y_in;
      r1_ff        <= r1_in;
      r2_ff        <= r2_in;
      dval_ff      <= dval_in;
      d_pos_ff     <= d_pos_in;
      rr_ff        <= rr_in;
      dd_ff        <= dd_in;
      kind_ff      <= kind_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
   end

   always_comb begin
      status.oper         = oper_ff;
      status.pressed      = pressed_ff;
      status.anchor_valid = anchor_valid_ff;
      status.scanning     = scanning_ff;
      status.scan_done    = (half_w_ff == '0) || (half_h_ff == '0)
                          || (scan_dx_ff >= {half_w_ff, 1'b0});
      status.root_busy    = root_busy;
      status.hit          = d_pos_ff && ({rr_ff, 2'b00} < {2'b00, dd_ff});
      status.out_free     = out_free;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_color = rsp_color_ff;

endmodule

[src/defr_ctrl.sv]
// ----------------------------------------------------------------------------
// defr_ctrl
// Sequencer for event decode, box setup and the per-tick pixel test.
// ----------------------------------------------------------------------------
module defr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  defr_pkg::status_type status,
   output defr_pkg::cmd_type    cmd
);

   defr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= defr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = defr_pkg::DP_NOP;
      cmd.set_kind = 1'b0;
      cmd.kind     = defr_pkg::KIND_CLEAR;
      req_stall    = (state_ff != defr_pkg::ST_IDLE);

      unique case (state_ff)
         defr_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = defr_pkg::DP_CAPTURE;
               state_in = defr_pkg::ST_DECODE;
            end
         end
         defr_pkg::ST_DECODE: begin
            if (status.oper == defr_pkg::OPER_MOUSE) begin
               if (!status.pressed) begin
                  cmd.op       = defr_pkg::DP_RELEASE;
                  cmd.set_kind = 1'b1;
                  cmd.kind     = defr_pkg::KIND_COMMIT;
                  state_in     = defr_pkg::ST_EMIT;
               end else if (!status.anchor_valid) begin
                  cmd.op   = defr_pkg::DP_SET_ANCHOR;
                  state_in = defr_pkg::ST_IDLE;
               end else begin
                  cmd.op   = defr_pkg::DP_BOX;
                  state_in = defr_pkg::ST_SQUARE;
               end
            end else if (!status.scanning) begin
               state_in = defr_pkg::ST_IDLE;
            end else if (status.scan_done) begin
               cmd.op       = defr_pkg::DP_STOP;
               cmd.set_kind = 1'b1;
               cmd.kind     = defr_pkg::KIND_UPDATE;
               state_in     = defr_pkg::ST_EMIT;
            end else begin
               cmd.op   = defr_pkg::DP_PIX_DIFF;
               state_in = defr_pkg::ST_PIX_SQ;
            end
         end
         defr_pkg::ST_SQUARE: begin
            cmd.op   = defr_pkg::DP_SQUARE;
            state_in = defr_pkg::ST_ROOT_LOAD;
         end
         defr_pkg::ST_ROOT_LOAD: begin
            cmd.op   = defr_pkg::DP_ROOT_START;
            state_in = defr_pkg::ST_ROOT_RUN;
         end
         defr_pkg::ST_ROOT_RUN: begin
            if (!status.root_busy) begin
               cmd.op       = defr_pkg::DP_ROOT_SAVE;
               cmd.set_kind = 1'b1;
               cmd.kind     = defr_pkg::KIND_CLEAR;
               state_in     = defr_pkg::ST_EMIT;
            end
         end
         defr_pkg::ST_PIX_SQ: begin
            cmd.op   = defr_pkg::DP_PIX_SQ;
            state_in = defr_pkg::ST_PIX_SUM;
         end
         defr_pkg::ST_PIX_SUM: begin
            cmd.op   = defr_pkg::DP_PIX_SUM;
            state_in = defr_pkg::ST_PIX_MUL;
         end
         defr_pkg::ST_PIX_MUL: begin
            cmd.op   = defr_pkg::DP_PIX_MUL;
            state_in = defr_pkg::ST_PIX_STEP;
         end
         defr_pkg::ST_PIX_STEP: begin
            cmd.op = defr_pkg::DP_PIX_STEP;
            if (status.hit) begin
               cmd.set_kind = 1'b1;
               cmd.kind     = defr_pkg::KIND_PIXEL;
               state_in     = defr_pkg::ST_EMIT;
            end else begin
               state_in = defr_pkg::ST_IDLE;
            end
         end
         defr_pkg::ST_EMIT: begin
            // hold until the result register can take the word
            if (status.out_free) begin
               cmd.op   = defr_pkg::DP_EMIT;
               state_in = defr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = defr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[src/drag_ellipse_fill_rasterizer.sv]
// ----------------------------------------------------------------------------
// drag_ellipse_fill_rasterizer
// Drag-to-draw filled ellipse: mouse words set up a box, tick words scan it.
// ----------------------------------------------------------------------------
// Each request word is either a mouse event or a scan tick, and the block
// handles one word at a time: req_stall is high from the cycle after a word
// is taken until its work is done. A release answers with a commit word. A
// first press only stores the anchor. A press with an anchor held computes
// the box (half spans, center, squares) and then runs the focal offset
// through an iterative square root that yields one result bit per cycle;
// it is answered by a clear word. A tick while idle gives no answer, and
// the tick that ends a scan answers with an update word. A tick that tests
// a pixel walks the inside test through five register steps (focus
// differences, squares, sums, products, compare), and answers with a pixel
// word when the pixel lies inside. The result sits in an output register,
// so a finished word waits there while the next request is taken; only
// when a second result is ready before the first is taken does the block
// hold. Positions beyond the canvas saturate to CANVAS_SIZE - 1. The color
// register may be written only while the block is idle.
// ----------------------------------------------------------------------------
module drag_ellipse_fill_rasterizer #(
   parameter int unsigned CANVAS_SIZE = defr_pkg::CANVAS_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_operation,
   input  logic                              req_pressed,
   input  logic [defr_pkg::COORD_W-1:0]      req_pos_x,
   input  logic [defr_pkg::COORD_W-1:0]      req_pos_y,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_kind,
   output logic [defr_pkg::COORD_W-1:0]      rsp_pixel_x,
   output logic [defr_pkg::COORD_W-1:0]      rsp_pixel_y,
   output logic [defr_pkg::COLOR_W-1:0]      rsp_pixel_color,
   // draw color register
   input  logic                              csr_wr_en,
   input  logic [defr_pkg::COLOR_W-1:0]      csr_wr_data
);

   defr_pkg::cmd_type    cmd;
   defr_pkg::status_type status;

   // sequencer: decode the word, step setup and pixel test, hand off result
   defr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: drag state, box, scan counters, inside test, result register
   defr_datapath #(
      .CANVAS_SIZE (CANVAS_SIZE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_operation),
      .req_pressed     (req_pressed),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color)
   );

endmodule

[src/defr_checker.sv]
// ----------------------------------------------------------------------------
// defr_checker
// Port-level checks for the ellipse rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module defr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [1:0]                        rsp_kind,
   input logic [defr_pkg::COORD_W-1:0]      rsp_pixel_x,
   input logic [defr_pkg::COORD_W-1:0]      rsp_pixel_y,
   input logic [defr_pkg::COLOR_W-1:0]      rsp_pixel_color
);

   // only pixel words carry position and color
   `DEFR_ASSERT_IMP(a_nonpixel_zero, clock, reset, rsp_valid && rsp_kind != defr_pkg::KIND_PIXEL, rsp_pixel_x == '0 && rsp_pixel_y == '0 && rsp_pixel_color == '0)

   // one word at a time: busy right after taking one
   `DEFR_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // a stalled result holds
   `DEFR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_pixel_x) && $stable(rsp_pixel_y))

endmodule

bind drag_ellipse_fill_rasterizer defr_checker u_checker (.*);

[tb/drag_ellipse_fill_rasterizer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drag_ellipse_fill_rasterizer_test
// Self-checking bench: mouse drags and scan ticks go in, and every result word
// is compared with a shadow rasterizer that tracks anchor, box and scan state.
// ----------------------------------------------------------------------------
module drag_ellipse_fill_rasterizer_test;
   import defr_pkg::*;

   localparam int CANVAS_MAX   = int'(CANVAS_SIZE_DEF) - 1;
   localparam int CYCLE_LIMIT  = 250000;
   localparam int DRAIN_CYCLES = 40;    // longer than the slowest request (press setup)
   localparam int HOLD_START   = 150;   // request words taken before the long hold-off
   localparam int HOLD_CYCLES  = 400;
   localparam int MAX_REPORTS  = 10;
   localparam int CHUNK_WORDS  = 100;
   localparam int CHUNK_COUNT  = 4;

   typedef struct packed {
      oper_type           oper;
      logic               pressed;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
   } gesture_word_type;

   typedef struct packed {
      kind_type           kind;
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [COLOR_W-1:0] pixel_color;
   } raster_word_type;

   // DUT ports, all inputs known from time zero
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_operation = 1'b0;
   logic               req_pressed = 1'b0;
   logic [COORD_W-1:0] req_pos_x = '0;
   logic [COORD_W-1:0] req_pos_y = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_kind;
   logic [COORD_W-1:0] rsp_pixel_x;
   logic [COORD_W-1:0] rsp_pixel_y;
   logic [COLOR_W-1:0] rsp_pixel_color;
   logic               csr_wr_en = 1'b0;
   logic [COLOR_W-1:0] csr_wr_data = '0;

   drag_ellipse_fill_rasterizer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_pressed     (req_pressed),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Stimulus and expectation stores
   gesture_word_type pending_gestures[$];
   raster_word_type  expected_raster[$];

   // Shadow copy of the rasterizer state and the draw color register
   logic               sh_anchor_held = 1'b0;
   logic [COORD_W-1:0] sh_anchor_x = '0;
   logic [COORD_W-1:0] sh_anchor_y = '0;
   logic [COORD_W-1:0] sh_center_x = '0;
   logic [COORD_W-1:0] sh_center_y = '0;
   logic [HALF_W-1:0]  sh_half_w = '0;
   logic [HALF_W-1:0]  sh_half_h = '0;
   logic [HALF_W-1:0]  sh_focal = '0;
   logic [COORD_W-1:0] sh_scan_u = '0;
   logic [COORD_W-1:0] sh_scan_v = '0;
   logic               sh_scanning = 1'b0;
   logic [COLOR_W-1:0] sh_color = COLOR_RESET;

   // Bookkeeping
   int  words_in = 0;       // request words taken
   int  words_out = 0;      // result words taken
   int  mismatches = 0;
   int  kind_seen[4] = '{0, 0, 0, 0};
   int  queued = 0;
   int  cycle_count = 0;
   bit  no_gaps = 1'b0;     // shared stretch with no idling on either side
   logic hold_req = 1'b0;
   int  hold_count = 0;

   // Driver locals
   int               gap_left = 0;
   gesture_word_type held_word;
   // Monitor locals
   int               stall_left = 0;
   raster_word_type  want;

   // Floor square root, one result bit per pair of input bits
   function automatic logic [31:0] floor_root(input logic [31:0] value);
      logic [31:0] rem, res, probe;
      rem   = value;
      res   = '0;
      probe = 32'h4000_0000;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= res + probe) begin
            rem = rem - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   // Strict inside test, sqrt(r1) + sqrt(r2) < R done by squaring
   function automatic bit in_ellipse(input longint u, input longint v);
      longint fx, fy, r1, r2, span, d;
      fx = 0;
      fy = 0;
      if (sh_half_w > sh_half_h) fx = longint'(sh_focal);
      else if (sh_half_h > sh_half_w) fy = longint'(sh_focal);
      span = 2 * longint'(sh_half_w > sh_half_h ? sh_half_w : sh_half_h);
      r1 = (u - fx) * (u - fx) + (v - fy) * (v - fy);
      r2 = (u + fx) * (u + fx) + (v + fy) * (v + fy);
      d  = span * span - r1 - r2;
      if (d <= 0) return 1'b0;
      return (4 * r1 * r2) < (d * d);
   endfunction

   function automatic int clamp_coord(input logic [COORD_W-1:0] p);
      return (int'(p) > CANVAS_MAX) ? CANVAS_MAX : int'(p);
   endfunction

   // Advance the shadow state by one taken word and queue the result it causes
   task automatic rasterize_gesture(input gesture_word_type g);
      raster_word_type r;
      bit              emits, hit;
      int              px, py, a, b, sq_a, sq_b;
      longint          u, v;
      r     = '0;
      emits = 1'b0;
      if (g.oper == OPER_MOUSE) begin
         px = clamp_coord(g.pos_x);
         py = clamp_coord(g.pos_y);
         // any mouse word drops a running scan
         sh_scanning = 1'b0;
         if (!g.pressed) begin
            sh_anchor_held = 1'b0;
            r.kind = KIND_COMMIT;
            emits  = 1'b1;
         end else if (!sh_anchor_held) begin
            sh_anchor_held = 1'b1;
            sh_anchor_x    = COORD_W'(px);
            sh_anchor_y    = COORD_W'(py);
         end else begin
            a = (int'(sh_anchor_x) > px) ? int'(sh_anchor_x) - px : px - int'(sh_anchor_x);
            b = (int'(sh_anchor_y) > py) ? int'(sh_anchor_y) - py : py - int'(sh_anchor_y);
            a = a / 2;
            b = b / 2;
            sq_a = a * a;
            sq_b = b * b;
            sh_half_w   = HALF_W'(a);
            sh_half_h   = HALF_W'(b);
            sh_focal    = HALF_W'(floor_root(sq_a > sq_b ? sq_a - sq_b : sq_b - sq_a));
            sh_center_x = COORD_W'((int'(sh_anchor_x) + px) / 2);
            sh_center_y = COORD_W'((int'(sh_anchor_y) + py) / 2);
            sh_scan_u   = '0;
            sh_scan_v   = '0;
            sh_scanning = 1'b1;
            r.kind = KIND_CLEAR;
            emits  = 1'b1;
         end
      end else if (sh_scanning) begin
         if (sh_half_w == 0 || sh_half_h == 0 || int'(sh_scan_u) >= 2 * int'(sh_half_w)) begin
            sh_scanning = 1'b0;
            r.kind = KIND_UPDATE;
            emits  = 1'b1;
         end else begin
            u   = longint'(sh_scan_u) - longint'(sh_half_w);
            v   = longint'(sh_scan_v) - longint'(sh_half_h);
            hit = in_ellipse(u, v);
            // x outer, y inner
            sh_scan_v = sh_scan_v + COORD_W'(1);
            if (int'(sh_scan_v) >= 2 * int'(sh_half_h)) begin
               sh_scan_v = '0;
               sh_scan_u = sh_scan_u + COORD_W'(1);
            end
            if (hit) begin
               r.kind        = KIND_PIXEL;
               r.pixel_x     = COORD_W'(longint'(sh_center_x) + u);
               r.pixel_y     = COORD_W'(longint'(sh_center_y) + v);
               r.pixel_color = sh_color;
               emits = 1'b1;
            end
         end
      end
      if (emits) expected_raster.push_back(r);
   endtask

   task automatic queue_gesture(input oper_type oper, input logic pressed,
                                input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      gesture_word_type g;
      g.oper    = oper;
      g.pressed = pressed;
      g.pos_x   = x;
      g.pos_y   = y;
      pending_gestures.push_back(g);
      queued++;
   endtask

   // The given operation with a random button and position
   task automatic queue_random(input oper_type oper);
      queue_gesture(oper, 1'($urandom), COORD_W'($urandom), COORD_W'($urandom));
   endtask

   // A point a few pixels away, kept on the canvas
   function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] c);
      int p;
      p = int'(c) + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 9));
      if (p < 0) p = 0;
      if (p > CANVAS_MAX) p = CANVAS_MAX;
      return p[COORD_W-1:0];
   endfunction

   // Wait until every word is sent and answered, then let the block settle
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_gestures.size() != 0 || req_valid || expected_raster.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Driver: present one word at a time, hold it while stalled, then
   // idle for a drawn number of cycles before the next one.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            // the held word was taken at this edge
            rasterize_gesture(held_word);
            words_in <= words_in + 1;
            if (words_in % 64 == 63) no_gaps <= ($urandom_range(0, 3) == 0);
            gap_left = no_gaps ? 0 : $urandom_range(0, 7);
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_gestures.size() != 0) begin
            held_word = pending_gestures.pop_front();
            req_valid     <= 1'b1;
            req_operation <= held_word.oper;
            req_pressed   <= held_word.pressed;
            req_pos_x     <= held_word.pos_x;
            req_pos_y     <= held_word.pos_y;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check each taken result word against the oldest
   // expectation, then stall for a drawn number of cycles.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_raster.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result word: kind=%0d x=%0d y=%0d color=%h",
                           rsp_kind, rsp_pixel_x, rsp_pixel_y, rsp_pixel_color);
            end else begin
               want = expected_raster.pop_front();
               kind_seen[want.kind]++;
               if (rsp_kind !== want.kind || rsp_pixel_x !== want.pixel_x ||
                   rsp_pixel_y !== want.pixel_y || rsp_pixel_color !== want.pixel_color) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("result word %0d: expected kind=%0d x=%0d y=%0d color=%h, ",
                              words_out, want.kind, want.pixel_x, want.pixel_y,
                              want.pixel_color,
                              "got kind=%0d x=%0d y=%0d color=%h",
                              rsp_kind, rsp_pixel_x, rsp_pixel_y, rsp_pixel_color);
               end
            end
            words_out <= words_out + 1;
            stall_left = no_gaps ? 0 : $urandom_range(0, 7);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= hold_req || (stall_left > 0);
      end
   end

   // ------------------------------------------------------------------
   // Long hold-off: once enough words are in, stall the result side for
   // a fixed stretch so the output register fills and backs up requests.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         hold_req   <= 1'b0;
         hold_count <= 0;
      end else if (hold_count < HOLD_CYCLES && words_in >= HOLD_START) begin
         hold_req   <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         hold_req <= 1'b0;
      end
   end

   // Cycle counter and watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL drag_ellipse_fill_rasterizer");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus: directed words with the reset color, then random phases,
   // each under a new color written while the block is idle.
   // ------------------------------------------------------------------
   initial begin
      int                 phase;
      int                 span_a, span_b, scan_ticks;
      logic [COORD_W-1:0] anchor_x, anchor_y, end_x, end_y;
      logic [COLOR_W-1:0] next_color;
      gesture_word_type   idle_tick;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // tick with nothing to scan, release with no anchor
      queue_gesture(OPER_TICK, 1'b0, 11'd0, 11'd0);
      queue_gesture(OPER_MOUSE, 1'b0, 11'd2047, 11'd2047);
      // full-canvas circle from corner to corner, scan cut short
      queue_gesture(OPER_MOUSE, 1'b1, 11'd0, 11'd0);
      queue_gesture(OPER_MOUSE, 1'b1, 11'd2047, 11'd2047);
      queue_gesture(OPER_TICK, 1'b1, 11'd2047, 11'd0);
      queue_gesture(OPER_TICK, 1'b0, 11'd0, 11'd2047);
      // flat box: the first tick answers with the update, the next is idle
      queue_gesture(OPER_MOUSE, 1'b1, 11'd0, 11'd2047);
      queue_gesture(OPER_TICK, 1'b1, 11'd1365, 11'd682);
      queue_gesture(OPER_TICK, 1'b0, 11'd682, 11'd1365);
      queue_gesture(OPER_MOUSE, 1'b0, 11'd1024, 11'd1024);
      // wide box, foci on x, aborted by a tall box with foci on y
      queue_gesture(OPER_MOUSE, 1'b1, 11'd100, 11'd100);
      queue_gesture(OPER_MOUSE, 1'b1, 11'd104, 11'd102);
      repeat (3) queue_gesture(OPER_TICK, 1'b0, 11'd0, 11'd0);
      queue_gesture(OPER_MOUSE, 1'b1, 11'd102, 11'd104);
      repeat (9) queue_gesture(OPER_TICK, 1'b1, 11'd2047, 11'd2047);
      queue_gesture(OPER_MOUSE, 1'b0, 11'd5, 11'd5);
      wait_quiet();

      for (phase = 0; phase < CHUNK_COUNT; phase++) begin
         case (phase)
            0:       next_color = '1;
            1:       next_color = '0;
            default: next_color = $urandom;
         endcase
         @(posedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= next_color;
         @(posedge clock);
         csr_wr_en <= 1'b0;
         sh_color = next_color;

         // fill at the falling edge, away from the driver's rising edge
         @(negedge clock);
         queued = 0;
         while (queued < CHUNK_WORDS) begin
            if ($urandom_range(0, 9) < 8) begin
               // well-formed drag: maybe a release, anchor, up to two aborted boxes,
               // one box scanned to the end, maybe a release
               if ($urandom_range(0, 3) != 0)
                  queue_gesture(OPER_MOUSE, 1'b0, COORD_W'($urandom), COORD_W'($urandom));
               anchor_x = COORD_W'($urandom);
               anchor_y = COORD_W'($urandom);
               queue_gesture(OPER_MOUSE, 1'b1, anchor_x, anchor_y);
               repeat ($urandom_range(0, 2)) begin
                  queue_gesture(OPER_MOUSE, 1'b1, near_coord(anchor_x), near_coord(anchor_y));
                  repeat ($urandom_range(0, 6)) queue_random(OPER_TICK);
               end
               end_x = near_coord(anchor_x);
               end_y = near_coord(anchor_y);
               queue_gesture(OPER_MOUSE, 1'b1, end_x, end_y);
               span_a = ((anchor_x > end_x) ? int'(anchor_x) - int'(end_x)
                                            : int'(end_x) - int'(anchor_x)) / 2;
               span_b = ((anchor_y > end_y) ? int'(anchor_y) - int'(end_y)
                                            : int'(end_y) - int'(anchor_y)) / 2;
               scan_ticks = (span_a == 0 || span_b == 0) ? 1 : 4 * span_a * span_b + 1;
               repeat (scan_ticks) queue_random(OPER_TICK);
               if ($urandom_range(0, 1) != 0) begin
                  // tick after the scan is done; ignored, so not counted
                  idle_tick.oper    = OPER_TICK;
                  idle_tick.pressed = 1'($urandom);
                  idle_tick.pos_x   = COORD_W'($urandom);
                  idle_tick.pos_y   = COORD_W'($urandom);
                  pending_gestures.push_back(idle_tick);
               end
               if ($urandom_range(0, 2) == 0)
                  queue_gesture(OPER_MOUSE, 1'b0, COORD_W'($urandom), COORD_W'($urandom));
            end else begin
               // noise: any operation, any position
               repeat ($urandom_range(1, 4))
                  queue_random(oper_type'($urandom_range(0, 1)));
            end
         end
         wait_quiet();
      end

      $display("covered %0d request words and %0d result words under %0d draw colors",
               words_in, words_out, CHUNK_COUNT + 1);
      $display("results: %0d clear, %0d pixel, %0d update, %0d commit; %0d mismatches",
               kind_seen[KIND_CLEAR], kind_seen[KIND_PIXEL], kind_seen[KIND_UPDATE],
               kind_seen[KIND_COMMIT], mismatches);
      if (mismatches == 0) begin
         $display("PASS drag_ellipse_fill_rasterizer");
      end else begin
         $display("FAIL drag_ellipse_fill_rasterizer");
      end
      $finish;
   end

endmodule
